FILE: hw/rtl/ppgbd_pkg.sv
// Shared types, constants and coefficient table for the PPG beat detector.
package ppgbd_pkg;

    localparam int HIST_DEPTH = 32;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int NUM_COEF   = 12;
    localparam int TAP_W      = $clog2(NUM_COEF);
    localparam int COEF_W     = 13;

    // b-side address offset: wp - 22 + k == wp + (32 - 22) + k modulo the ring
    localparam logic [HIST_AW-1:0] PAIR_OFFSET = HIST_AW'(HIST_DEPTH - 22);
    localparam logic [TAP_W-1:0]   CENTER_TAP  = TAP_W'(NUM_COEF - 1);

    localparam logic [15:0] AMP_LOW_RST  = 16'd100;
    localparam logic [15:0] AMP_HIGH_RST = 16'd1000;

    typedef enum logic [0:0] {
        CFG_AMP_LOW  = 1'b0,
        CFG_AMP_HIGH = 1'b1
    } ppgbd_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DC,
        S_AC,
        S_FIR,
        S_DRAIN,
        S_POST
    } ppgbd_state_t;

    // Q15 low-pass coefficients, outermost tap pair first, center tap last.
    function automatic logic [COEF_W-1:0] fir_coef(input logic [TAP_W-1:0] idx);
        logic [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = 13'd172;
            4'd1:    c = 13'd321;
            4'd2:    c = 13'd579;
            4'd3:    c = 13'd927;
            4'd4:    c = 13'd1360;
            4'd5:    c = 13'd1858;
            4'd6:    c = 13'd2390;
            4'd7:    c = 13'd2916;
            4'd8:    c = 13'd3391;
            4'd9:    c = 13'd3768;
            4'd10:   c = 13'd4012;
            4'd11:   c = 13'd4096;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/ppg_beat_detector.sv
// PPG beat detector: DC removal, 23-tap FIR over a ring memory, zero-crossing beat flag.
// A new sample is accepted only after the previous result has been loaded for output;
// one multiplier walks the 11 tap pairs and the center tap, one per cycle, fed by
// the two read ports of the history memory.
// Reset (aresetn low, synchronous) clears control state, the DC accumulator and
// the history valid bits at once; no clearing pass, the block is ready next cycle.
module ppg_beat_detector
    import ppgbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] beat, [16:1] filtered, [32:17] dc_level, [39:33] zero
);

    ppgbd_state_t state_reg, state_next;

    logic [15:0] amp_low_reg, amp_high_reg;

    logic        [15:0] sample_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] acc_reg;
    logic        [15:0] dc_reg;
    logic [HIST_AW-1:0] wp_reg;

    // history memory with per-entry valid bits (unwritten entries read as zero)
    logic signed [15:0]   hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_vld_reg;

    logic [TAP_W-1:0]   tap_cnt_reg;
    logic [HIST_AW-1:0] addr_a, addr_b;

    logic signed [15:0] rd_a_reg, rd_b_reg;
    logic               rd_a_vld_reg, rd_b_vld_reg, rd_b_use_reg;
    logic [COEF_W-1:0]  rd_coef_reg;
    logic               rd_vld_reg;

    logic signed [15:0] pair;
    logic signed [29:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [33:0] z_reg;

    logic signed [15:0] cur_val_reg, cycle_max_reg, cycle_min_reg;
    logic               in_pos_reg, in_neg_reg;

    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    logic               in_accept, out_free, post_go;
    logic        [15:0] dc_now, ac_now;
    logic signed [15:0] cur, cmax_next, cmin_next;
    logic               rise, fall, in_pos_next, in_neg_next, beat;
    logic signed [16:0] amp_diff;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_DC;
            S_DC:    state_next = S_AC;
            S_AC:    state_next = S_FIR;
            S_FIR:   if (tap_cnt_reg == CENTER_TAP) state_next = S_DRAIN;
            S_DRAIN: if (!rd_vld_reg && !prod_vld_reg) state_next = S_POST;
            S_POST:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        in_accept = s_tvalid && s_tready;
        out_free  = !m_tvalid_reg || m_tready;
        post_go   = (state_reg == S_POST) && out_free;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- datapath logic ----------------
    assign dc_now = acc_reg[30:15];
    assign ac_now = sample_reg - dc_now;
    assign addr_a = wp_reg - HIST_AW'(tap_cnt_reg);
    assign addr_b = wp_reg + PAIR_OFFSET + HIST_AW'(tap_cnt_reg);

    always_comb begin
        logic signed [15:0] a_val, b_val;
        a_val = rd_a_vld_reg ? rd_a_reg : 16'sd0;
        b_val = (rd_b_vld_reg && rd_b_use_reg) ? rd_b_reg : 16'sd0;
        pair  = a_val + b_val;
    end

    always_comb begin
        cur      = z_reg[30:15];
        rise     = cur_val_reg[15] && !cur[15];
        fall     = !cur_val_reg[15] && (cur_val_reg != 16'sd0) &&
                   (cur[15] || cur == 16'sd0);
        amp_diff = 17'(cycle_max_reg) - 17'(cycle_min_reg);
        beat     = rise &&
                   ($signed({amp_diff[16], amp_diff}) > $signed({2'b00, amp_low_reg})) &&
                   ($signed({amp_diff[16], amp_diff}) < $signed({2'b00, amp_high_reg}));

        in_pos_next = rise ? 1'b1 : (fall ? 1'b0 : in_pos_reg);
        in_neg_next = rise ? 1'b0 : (fall ? 1'b1 : in_neg_reg);

        cmax_next = rise ? 16'sd0 : cycle_max_reg;
        if (in_pos_next && cur > cur_val_reg) begin
            cmax_next = cur;
        end
        cmin_next = fall ? 16'sd0 : cycle_min_reg;
        if (in_neg_next && cur < cur_val_reg) begin
            cmin_next = cur;
        end
    end

    // ---------------- history memory ----------------
    always_ff @(posedge aclk) begin
        if (state_reg == S_AC) begin
            hist_mem[wp_reg] <= ac_now;
        end
        rd_a_reg <= hist_mem[addr_a];
        rd_b_reg <= hist_mem[addr_b];
    end

    // ---------------- registers with reset ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            amp_low_reg   <= AMP_LOW_RST;
            amp_high_reg  <= AMP_HIGH_RST;
            acc_reg       <= '0;
            wp_reg        <= '0;
            hist_vld_reg  <= '0;
            tap_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            rd_a_vld_reg  <= 1'b0;
            rd_b_vld_reg  <= 1'b0;
            prod_vld_reg  <= 1'b0;
            cur_val_reg   <= '0;
            cycle_max_reg <= '0;
            cycle_min_reg <= '0;
            in_pos_reg    <= 1'b0;
            in_neg_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_AMP_LOW:  amp_low_reg  <= cfg_wdata;
                    CFG_AMP_HIGH: amp_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (state_reg == S_DC) begin
                acc_reg <= acc_reg + 32'(diff_reg >>> 4);
            end

            if (state_reg == S_AC) begin
                hist_vld_reg[wp_reg] <= 1'b1;
                tap_cnt_reg          <= '0;
            end else if (state_reg == S_FIR) begin
                tap_cnt_reg <= tap_cnt_reg + TAP_W'(1);
            end

            rd_vld_reg   <= (state_reg == S_FIR);
            rd_a_vld_reg <= hist_vld_reg[addr_a];
            rd_b_vld_reg <= hist_vld_reg[addr_b];
            prod_vld_reg <= rd_vld_reg;

            if (post_go) begin
                wp_reg        <= wp_reg + HIST_AW'(1);
                cur_val_reg   <= cur;
                cycle_max_reg <= cmax_next;
                cycle_min_reg <= cmin_next;
                in_pos_reg    <= in_pos_next;
                in_neg_reg    <= in_neg_next;
            end

            if (post_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            sample_reg <= s_tdata;
            diff_reg   <= $signed({2'b00, s_tdata, 15'd0}) - 33'(acc_reg);
        end
        if (state_reg == S_AC) begin
            dc_reg <= dc_now;
            z_reg  <= '0;
        end else if (prod_vld_reg) begin
            z_reg <= z_reg + 34'(prod_reg);
        end
        if (state_reg == S_FIR) begin
            rd_coef_reg  <= fir_coef(tap_cnt_reg);
            rd_b_use_reg <= (tap_cnt_reg != CENTER_TAP);
        end
        if (rd_vld_reg) begin
            prod_reg <= 30'(pair) * 30'($signed({1'b0, rd_coef_reg}));
        end
        if (post_go) begin
            m_tdata_reg <= {7'd0, dc_reg, cur, beat};
        end
    end

`ifndef SYNTH
    // the tap walk stops at the center tap
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIR) |-> (tap_cnt_reg <= CENTER_TAP))
        else $error("tap counter past center tap");

    // a product is registered only from read data that was valid the cycle before
    a_prod_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> $past(rd_vld_reg))
        else $error("product without preceding read");

    // the ring pointer moves by one exactly when a result is loaded
    a_wp_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        post_go |=> (wp_reg == $past(wp_reg) + HIST_AW'(1)))
        else $error("write pointer did not advance");

    // the filter sum is complete before the result is formed
    a_post_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POST) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("result formed with products in flight");

    // an accepted item yields a result item only after the full walk
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !post_go)
        else $error("result loaded right after accept");
`endif

endmodule
